@@ rtl/core/nss_pkg.sv @@
// Package for the brute-force substring search block.
// Request and status codes, payload structs, search states and defaults.
// No dependencies.
package nss_pkg;

	// default buffer capacity in bytes
	localparam int unsigned MAX_LEN_DEF = 128;

	typedef enum logic [1:0] {
		REQ_TEXT   = 2'd0,
		REQ_PAT    = 2'd1,
		REQ_SEARCH = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BAD       = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_byte;
		logic       first_of_string;
		logic [7:0] start_pos;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] match_pos;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_DONE
	} srch_state_t;

endpackage

@@ rtl/core/naive_substring_search.sv @@
// Top level of the brute-force substring search block.
// Depends on nss_pkg, nss_mem (text and pattern stores) and nss_seq.
//
// Requests arrive on req (valid/stall); results leave on rsp (valid/stall).
// Append requests write one byte into the text or pattern store and are
// taken one per cycle outside a search, even while a result waits on rsp.
// first_of_string restarts the chosen buffer; bytes past MAX_LEN are dropped.
// A search request gives exactly one result; request code 3 is ignored.
// Search steps: each byte compare is a store read (S_READ), then the compare
// (S_CMP), since both stores have a registered read. A bad request (empty
// pattern or start 0) goes straight to S_DONE without reading the stores.
// The number of byte compares is at most about text_length * pattern_length
// for a full brute-force walk. req_stall stays high while a search runs and
// until its result has moved into the output register.
// Reset clears both lengths, the sequencer and the output valid; store
// contents are left as they are and are only read below the current length.
// A stalled rsp holds its payload; a finished search then waits in the
// sequencer, which keeps req_stall high.
module naive_substring_search #(
	parameter int unsigned MAX_LEN = nss_pkg::MAX_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  nss_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output nss_pkg::rsp_t rsp
);

	localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned LW = $clog2(MAX_LEN + 1);

	logic          req_acc;
	logic          app_text, app_pat, do_search;
	logic [LW-1:0] text_len_q, pat_len_q;
	logic          text_we, pat_we;
	logic [AW-1:0] text_waddr, pat_waddr;
	logic [AW-1:0] text_raddr, pat_raddr;
	logic [7:0]    text_rdata, pat_rdata;
	logic          busy, res_vld, res_rdy, res_load;
	nss_pkg::rsp_t res;
	logic          rsp_valid_q;
	nss_pkg::rsp_t rsp_q;

	assign req_stall = busy;
	assign req_acc   = req_valid && !req_stall;
	assign app_text  = req_acc && (req.req_type == nss_pkg::REQ_TEXT);
	assign app_pat   = req_acc && (req.req_type == nss_pkg::REQ_PAT);
	assign do_search = req_acc && (req.req_type == nss_pkg::REQ_SEARCH);

	// appends: a restart writes entry 0, otherwise the next free entry if any
	assign text_we    = app_text && (req.first_of_string || text_len_q < LW'(MAX_LEN));
	assign pat_we     = app_pat && (req.first_of_string || pat_len_q < LW'(MAX_LEN));
	assign text_waddr = req.first_of_string ? '0 : text_len_q[AW-1:0];
	assign pat_waddr  = req.first_of_string ? '0 : pat_len_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_len_q <= '0;
			pat_len_q  <= '0;
		end else begin
			if (text_we) begin
				text_len_q <= req.first_of_string ? LW'(1) : text_len_q + LW'(1);
			end
			if (pat_we) begin
				pat_len_q <= req.first_of_string ? LW'(1) : pat_len_q + LW'(1);
			end
		end
	end

	nss_mem #(
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_text_mem (
		.clk   (clk),
		.we    (text_we),
		.waddr (text_waddr),
		.wdata (req.char_byte),
		.raddr (text_raddr),
		.rdata (text_rdata)
	);

	nss_mem #(
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_pat_mem (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (req.char_byte),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	// stores are never written during a search: req_stall interlocks them
	nss_seq #(
		.AW      (AW),
		.LW      (LW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (do_search),
		.start_pos  (req.start_pos),
		.text_len   (text_len_q),
		.pat_len    (pat_len_q),
		.text_raddr (text_raddr),
		.pat_raddr  (pat_raddr),
		.text_rdata (text_rdata),
		.pat_rdata  (pat_rdata),
		.busy       (busy),
		.res_vld    (res_vld),
		.res_rdy    (res_rdy),
		.res        (res)
	);

	// output register
	assign res_rdy  = !rsp_valid_q || !rsp_stall;
	assign res_load = res_vld && res_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(text_len_q <= LW'(MAX_LEN)) && (pat_len_q <= LW'(MAX_LEN)))
		else $error("buffer length beyond capacity");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(text_we || pat_we))
		else $error("store written during a search");

	a_search_locks: assert property (@(posedge clk) disable iff (!arst_n)
		do_search |=> req_stall)
		else $error("search accepted without locking the request side");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res.status != nss_pkg::ST_FOUND) |=> (rsp.match_pos == 8'd0))
		else $error("non-zero position on a miss or bad request");

endmodule

@@ rtl/core/nss_mem.sv @@
// Byte store with one write port and one registered read port.
// Used for both the text and the pattern buffer. No package use.
module nss_mem #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned AW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/nss_seq.sv @@
// Search sequencer: walks text and pattern stores, one byte compare per step.
// Depends on nss_pkg; reads both stores through their registered ports.
module nss_seq #(
	parameter int unsigned AW      = 7,
	parameter int unsigned LW      = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [7:0]       start_pos,
	input  logic [LW-1:0]    text_len,
	input  logic [LW-1:0]    pat_len,
	output logic [AW-1:0]    text_raddr,
	output logic [AW-1:0]    pat_raddr,
	input  logic [7:0]       text_rdata,
	input  logic [7:0]       pat_rdata,
	output logic             busy,
	output logic             res_vld,
	input  logic             res_rdy,
	output nss_pkg::rsp_t    res
);

	// text index must hold start - 1 (up to 254) as well as the text length
	localparam int unsigned TW = (LW > 8) ? LW : 8;

	nss_pkg::srch_state_t state_q, state_d;
	logic [TW-1:0] ti_q, ti_d;
	logic [LW-1:0] pj_q, pj_d;
	nss_pkg::rsp_t res_q, res_d;
	logic [TW-1:0] align;

	assign text_raddr = ti_q[AW-1:0];
	assign pat_raddr  = pj_q[AW-1:0];
	assign align      = ti_q - TW'(pj_q) + TW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nss_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		ti_q  <= ti_d;
		pj_q  <= pj_d;
		res_q <= res_d;
	end

	always_comb begin
		state_d = state_q;
		ti_d    = ti_q;
		pj_d    = pj_q;
		res_d   = res_q;
		case (state_q)
			nss_pkg::S_IDLE: begin
				if (start) begin
					if (pat_len == '0 || start_pos == 8'd0) begin
						res_d.status    = nss_pkg::ST_BAD;
						res_d.match_pos = 8'd0;
						state_d         = nss_pkg::S_DONE;
					end else begin
						ti_d    = TW'(start_pos) - TW'(1);
						pj_d    = '0;
						state_d = nss_pkg::S_READ;
					end
				end
			end
			nss_pkg::S_READ: begin
				// loop test; addresses go to the stores this cycle
				if (ti_q < TW'(text_len) && pj_q < pat_len) begin
					state_d = nss_pkg::S_CMP;
				end else begin
					if (pj_q >= pat_len) begin
						res_d.status    = nss_pkg::ST_FOUND;
						res_d.match_pos = align[7:0];
					end else begin
						res_d.status    = nss_pkg::ST_NOT_FOUND;
						res_d.match_pos = 8'd0;
					end
					state_d = nss_pkg::S_DONE;
				end
			end
			nss_pkg::S_CMP: begin
				if (text_rdata == pat_rdata) begin
					ti_d = ti_q + TW'(1);
					pj_d = pj_q + LW'(1);
				end else begin
					// back up to one past the current alignment
					ti_d = align;
					pj_d = '0;
				end
				state_d = nss_pkg::S_READ;
			end
			nss_pkg::S_DONE: begin
				if (res_rdy) begin
					state_d = nss_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nss_pkg::S_IDLE;
			end
		endcase
	end

	assign busy    = (state_q != nss_pkg::S_IDLE);
	assign res_vld = (state_q == nss_pkg::S_DONE);
	assign res     = res_q;

endmodule
